// File: design/drt_pkg.sv
`default_nettype none

package drt_pkg;

	localparam int LEVEL_FRAC_BITS = 8;
	localparam int COUNTER_WIDTH   = 32;

	localparam int NUM_CH = 3;
	localparam int LEVEL_W = 24;
	localparam int CFG_W = 16;
	localparam int REPORT_W = 16;
	localparam int CFG_IDX_W = 3;

	localparam int SECONDS_PER_MINUTE = 60;
	localparam int MAX_SEC_W = CFG_W + 6;

	localparam int DIFF_W = LEVEL_W + 1;
	localparam int LIM_W = CFG_W + LEVEL_FRAC_BITS;
	localparam int CMP_W = (DIFF_W > LIM_W) ? DIFF_W : LIM_W;
	localparam int PROD_W = LEVEL_W + 4;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_SECONDS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_MINUTES = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HELIUM_THR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_N2A_THR     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_N2B_THR     = 3'd4;

	localparam logic [CFG_W-1:0] MIN_SECONDS_RST = CFG_W'(60);
	localparam logic [MAX_SEC_W-1:0] MAX_SECONDS_RST = MAX_SEC_W'(60 * SECONDS_PER_MINUTE);
	localparam logic [CFG_W-1:0] THRESHOLD_RST = CFG_W'(1);

	typedef struct packed {
		logic                      tick_second;
		logic                      link_up;
		logic                      sample_valid;
		logic signed [LEVEL_W-1:0] helium_level;
		logic signed [LEVEL_W-1:0] nitrogen_a_level;
		logic signed [LEVEL_W-1:0] nitrogen_b_level;
	} in_item_t;

	typedef struct packed {
		logic                report_now;
		logic [REPORT_W-1:0] helium_report;
		logic [REPORT_W-1:0] nitrogen_a_report;
		logic [REPORT_W-1:0] nitrogen_b_report;
	} out_item_t;

	typedef struct packed {
		logic [CFG_W-1:0]                  min_seconds;
		logic [MAX_SEC_W-1:0]              max_seconds;
		logic [NUM_CH-1:0][CFG_W-1:0]      threshold;
	} cfg_t;

endpackage

`default_nettype wire

// File: design/drt_cfg.sv
`default_nettype none

module drt_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [drt_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [drt_pkg::CFG_W-1:0]      cfg_data,
	output drt_pkg::cfg_t                       cfg
);
	import drt_pkg::*;

	logic [CFG_W-1:0]             min_seconds_q;
	logic [MAX_SEC_W-1:0]         max_seconds_q;
	logic [NUM_CH-1:0][CFG_W-1:0] threshold_q;
	logic [MAX_SEC_W-1:0]         data_ext;
	logic [MAX_SEC_W-1:0]         minutes_to_sec;

	// minutes * 60 = minutes * 64 - minutes * 4
	assign data_ext = MAX_SEC_W'(cfg_data);
	assign minutes_to_sec = (data_ext << 6) - (data_ext << 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_seconds_q <= MIN_SECONDS_RST;
			max_seconds_q <= MAX_SECONDS_RST;
			threshold_q   <= {NUM_CH{THRESHOLD_RST}};
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MIN_SECONDS: min_seconds_q  <= cfg_data;
				REG_MAX_MINUTES: max_seconds_q  <= minutes_to_sec;
				REG_HELIUM_THR:  threshold_q[0] <= cfg_data;
				REG_N2A_THR:     threshold_q[1] <= cfg_data;
				REG_N2B_THR:     threshold_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.min_seconds = min_seconds_q;
	assign cfg.max_seconds = max_seconds_q;
	assign cfg.threshold   = threshold_q;

endmodule

`default_nettype wire

// File: design/drt_chan.sv
`default_nettype none

module drt_chan (
	input  wire logic signed [drt_pkg::LEVEL_W-1:0] level,
	input  wire logic signed [drt_pkg::LEVEL_W-1:0] reported,
	input  wire logic [drt_pkg::CFG_W-1:0]          threshold,
	output logic                                    moved,
	output logic [drt_pkg::REPORT_W-1:0]            report
);
	import drt_pkg::*;

	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]        mag;
	logic [CMP_W-1:0]         mag_ext;
	logic [CMP_W-1:0]         lim_ext;
	logic [PROD_W-1:0]        lvl_ext;
	logic [PROD_W-1:0]        prod;
	logic [PROD_W-1:0]        scaled;
	logic                     positive;

	assign diff = DIFF_W'(level) - DIFF_W'(reported);
	assign mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
	assign mag_ext = CMP_W'(mag);
	assign lim_ext = CMP_W'({threshold, {LEVEL_FRAC_BITS{1'b0}}});
	assign moved = mag_ext > lim_ext;

	// level * 10 = level * 8 + level * 2, then drop the fraction bits
	assign positive = !level[LEVEL_W-1] && (level != '0);
	assign lvl_ext = PROD_W'($unsigned(level));
	assign prod = (lvl_ext << 3) + (lvl_ext << 1);
	assign scaled = prod >> LEVEL_FRAC_BITS;

	always_comb begin
		if (!positive) begin
			report = '0;
		end else if (scaled > PROD_W'({REPORT_W{1'b1}})) begin
			report = {REPORT_W{1'b1}};
		end else begin
			report = scaled[REPORT_W-1:0];
		end
	end

endmodule

`default_nettype wire

// File: design/deadband_report_trigger_unit.sv
`default_nettype none

// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall | in_item (drt_pkg::in_item_t)
// out     | output    | out_valid/out_stall | out_item (drt_pkg::out_item_t)
// cfg     | input     | cfg_we              | cfg_idx, cfg_data
//
// One item per cycle while not stalled; input register, then result register.
// State (readings, last reported, seconds counter) updates as an item moves from
// the input register to the result register, so the next item sees it directly.
// Reset clears readings and counter and loads register defaults.
// in_stall rises only when both registers are full and out_stall is high.

module deadband_report_trigger_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire drt_pkg::in_item_t             in_item,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output drt_pkg::out_item_t                 out_item,
	input  wire logic                          cfg_we,
	input  wire logic [drt_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [drt_pkg::CFG_W-1:0]     cfg_data
);
	import drt_pkg::*;

	cfg_t cfg;

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_s2;
	logic      valid_s2;

	logic signed [LEVEL_W-1:0] cur_q [NUM_CH];
	logic signed [LEVEL_W-1:0] rep_q [NUM_CH];
	logic [COUNTER_WIDTH-1:0]  cnt_q;

	logic signed [LEVEL_W-1:0] lvl_in   [NUM_CH];
	logic signed [LEVEL_W-1:0] cur_next [NUM_CH];
	logic [NUM_CH-1:0]         moved;
	logic [REPORT_W-1:0]       report [NUM_CH];
	logic [COUNTER_WIDTH-1:0]  cnt_inc;
	logic                      max_ok;
	logic                      min_ok;
	logic                      fire;
	logic                      advance;
	logic                      accept;

	drt_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign lvl_in[0] = item_s1.helium_level;
	assign lvl_in[1] = item_s1.nitrogen_a_level;
	assign lvl_in[2] = item_s1.nitrogen_b_level;

	for (genvar i = 0; i < NUM_CH; i++) begin : g_ch
		assign cur_next[i] = item_s1.sample_valid ? lvl_in[i] : cur_q[i];

		drt_chan u_chan (
			.level     (cur_next[i]),
			.reported  (rep_q[i]),
			.threshold (cfg.threshold[i]),
			.moved     (moved[i]),
			.report    (report[i])
		);
	end

	assign cnt_inc = (item_s1.tick_second && (cnt_q != {COUNTER_WIDTH{1'b1}})) ?
		cnt_q + COUNTER_WIDTH'(1) : cnt_q;
	assign max_ok = cnt_inc >= COUNTER_WIDTH'(cfg.max_seconds);
	assign min_ok = cnt_inc >= COUNTER_WIDTH'(cfg.min_seconds);
	assign fire = item_s1.link_up && (max_ok || (min_ok && (moved != '0)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
		if (advance) begin
			res_s2.report_now        <= fire;
			res_s2.helium_report     <= fire ? report[0] : '0;
			res_s2.nitrogen_a_report <= fire ? report[1] : '0;
			res_s2.nitrogen_b_report <= fire ? report[2] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int i = 0; i < NUM_CH; i++) begin
				cur_q[i] <= '0;
				rep_q[i] <= '0;
			end
		end else if (advance) begin
			cnt_q <= fire ? '0 : cnt_inc;
			for (int i = 0; i < NUM_CH; i++) begin
				cur_q[i] <= cur_next[i];
				if (fire) begin
					rep_q[i] <= cur_next[i];
				end
			end
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = res_s2;

endmodule

`default_nettype wire

// File: design/drt_checker.sv
`default_nettype none

module drt_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire drt_pkg::out_item_t            out_item
);
	import drt_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result item changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result item without an accepted input item");

	a_quiet_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.report_now |->
			(out_item.helium_report == '0) && (out_item.nitrogen_a_report == '0) &&
			(out_item.nitrogen_b_report == '0))
		else $error("values present without a report");

endmodule

bind deadband_report_trigger_unit drt_checker u_drt_checker (.*);

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import drt_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int REPORT_SCALE = 10;
	localparam logic signed [LEVEL_W-1:0] LEVEL_TOP = 24'sh7FFFFF;
	localparam logic signed [LEVEL_W-1:0] LEVEL_BOTTOM = 24'sh800000;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 170;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_W-1:0]       val;
		in_item_t               item;
		bit                     typed;
		out_item_t              want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_data;

	logic [CFG_W-1:0] min_secs;
	logic [CFG_W-1:0] max_mins;
	logic [CFG_W-1:0] thr [NUM_CH];
	logic signed [LEVEL_W-1:0] lvl_now [NUM_CH];
	logic signed [LEVEL_W-1:0] lvl_sent [NUM_CH];
	logic [COUNTER_WIDTH-1:0] secs_idle;

	out_item_t pending_reports [$];
	plan_row_t plan [$];
	bit row_typed;
	out_item_t row_want;
	out_item_t predicted;
	out_item_t want;
	bit squeeze;
	int walk [NUM_CH];
	int mismatches;
	int items_in;
	int reports_seen;
	int reg_writes;
	int held_cycles;

	deadband_report_trigger_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("FAIL deadband_report_trigger_unit");
		$finish;
	end

	function automatic logic [REPORT_W-1:0] to_report(logic signed [LEVEL_W-1:0] lvl);
		longint scaled;
		if (lvl <= 0)
			return '0;
		scaled = (longint'(lvl) * REPORT_SCALE) >>> LEVEL_FRAC_BITS;
		return (scaled > 65535) ? 16'hFFFF : scaled[REPORT_W-1:0];
	endfunction

	function automatic out_item_t trigger_decision(in_item_t it);
		out_item_t r;
		bit change;
		bit fire;
		longint diff;
		change = 0;
		if (it.tick_second && secs_idle != '1)
			secs_idle = secs_idle + 1'b1;
		if (it.sample_valid) begin
			lvl_now[0] = it.helium_level;
			lvl_now[1] = it.nitrogen_a_level;
			lvl_now[2] = it.nitrogen_b_level;
		end
		for (int c = 0; c < NUM_CH; c++) begin
			diff = longint'(lvl_now[c]) - longint'(lvl_sent[c]);
			if (diff < 0)
				diff = -diff;
			if (diff > (longint'(thr[c]) << LEVEL_FRAC_BITS))
				change = 1;
		end
		fire = it.link_up && (longint'(secs_idle) >= longint'(max_mins) * SECONDS_PER_MINUTE
			|| (longint'(secs_idle) >= longint'(min_secs) && change));
		r.report_now = fire;
		r.helium_report = fire ? to_report(lvl_now[0]) : '0;
		r.nitrogen_a_report = fire ? to_report(lvl_now[1]) : '0;
		r.nitrogen_b_report = fire ? to_report(lvl_now[2]) : '0;
		if (fire) begin
			lvl_sent = lvl_now;
			secs_idle = '0;
		end
		return r;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		case (idx)
			REG_MIN_SECONDS: min_secs = val;
			REG_MAX_MINUTES: max_mins = val;
			REG_HELIUM_THR: thr[0] = val;
			REG_N2A_THR: thr[1] = val;
			REG_N2B_THR: thr[2] = val;
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				apply_reg(cfg_idx, cfg_data);
			if (in_valid && in_stall)
				held_cycles++;
			if (in_valid && !in_stall) begin
				predicted = trigger_decision(in_item);
				pending_reports.push_back(row_typed ? row_want : predicted);
				items_in++;
			end
			if (out_valid && !out_stall) begin
				if (pending_reports.size() == 0) begin
					$error("result with no item outstanding: %p", out_item);
					mismatches++;
				end else begin
					want = pending_reports.pop_front();
					if (out_item.report_now)
						reports_seen++;
					if (out_item.report_now !== want.report_now) begin
						$error("report_now: expected %0d, got %0d", want.report_now,
							out_item.report_now);
						mismatches++;
					end
					if (out_item.helium_report !== want.helium_report) begin
						$error("helium_report: expected %0d, got %0d", want.helium_report,
							out_item.helium_report);
						mismatches++;
					end
					if (out_item.nitrogen_a_report !== want.nitrogen_a_report) begin
						$error("nitrogen_a_report: expected %0d, got %0d",
							want.nitrogen_a_report, out_item.nitrogen_a_report);
						mismatches++;
					end
					if (out_item.nitrogen_b_report !== want.nitrogen_b_report) begin
						$error("nitrogen_b_report: expected %0d, got %0d",
							want.nitrogen_b_report, out_item.nitrogen_b_report);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		int r;
		int n;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 99);
			if (squeeze) begin
				repeat (100) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
				squeeze = 0;
			end else if (r < 40) begin
				n = $urandom_range(1, 25);
				repeat (n) begin
					@(negedge clk);
					out_stall <= 1'b0;
				end
			end else begin
				n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
				repeat (n) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (squeeze || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_item(in_item_t it, bit typed, out_item_t exp_out);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_item <= it;
		row_typed <= typed;
		row_want <= exp_out;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic in_item_t mk(logic tick, logic link, logic fresh,
		logic signed [LEVEL_W-1:0] he, logic signed [LEVEL_W-1:0] na,
		logic signed [LEVEL_W-1:0] nb);
		in_item_t it;
		it.tick_second = tick;
		it.link_up = link;
		it.sample_valid = fresh;
		it.helium_level = he;
		it.nitrogen_a_level = na;
		it.nitrogen_b_level = nb;
		return it;
	endfunction

	function automatic out_item_t rpt(logic fire, logic [REPORT_W-1:0] he,
		logic [REPORT_W-1:0] na, logic [REPORT_W-1:0] nb);
		out_item_t r;
		r.report_now = fire;
		r.helium_report = he;
		r.nitrogen_a_report = na;
		r.nitrogen_b_report = nb;
		return r;
	endfunction

	function automatic void add_item(in_item_t it, bit typed = 0, out_item_t w = '0);
		plan_row_t row;
		row.kind = ROW_ITEM;
		row.item = it;
		row.typed = typed;
		row.want = w;
		plan.push_back(row);
	endfunction

	function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		plan_row_t row;
		row.kind = ROW_WRITE;
		row.idx = idx;
		row.val = val;
		plan.push_back(row);
	endfunction

	function automatic logic [CFG_W-1:0] pick_reg(int zero_w, int lo, int hi);
		int r;
		r = $urandom_range(0, 9);
		if (r < zero_w)
			return '0;
		if (r == 9)
			return 16'hFFFF;
		if (r == 8)
			return CFG_W'($urandom);
		return CFG_W'($urandom_range(lo, hi));
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		logic signed [LEVEL_W-1:0] lv [NUM_CH];
		int r;
		int span;
		it = mk($urandom_range(0, 99) < 70, $urandom_range(0, 99) < 85,
			$urandom_range(0, 99) < 60, '0, '0, '0);
		for (int c = 0; c < NUM_CH; c++) begin
			r = $urandom_range(0, 99);
			if (!it.sample_valid || (r >= 80 && r < 92)) begin
				lv[c] = LEVEL_W'($urandom);
			end else if (r >= 92) begin
				lv[c] = $urandom_range(0, 1) ? LEVEL_TOP : LEVEL_BOTTOM;
			end else begin
				span = (int'(thr[c]) + 2) * 256;
				if (span > 4_000_000)
					span = 4_000_000;
				walk[c] = walk[c] + int'($urandom_range(0, 2 * span)) - span;
				if (walk[c] > 8388607)
					walk[c] = 8388607;
				if (walk[c] < -8388608)
					walk[c] = -8388608;
				lv[c] = walk[c][LEVEL_W-1:0];
			end
		end
		it.helium_level = lv[0];
		it.nitrogen_a_level = lv[1];
		it.nitrogen_b_level = lv[2];
		return it;
	endfunction

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		row_typed = 0;
		row_want = '0;
		squeeze = 0;
		min_secs = 16'd60;
		max_mins = 16'd60;
		secs_idle = '0;
		for (int c = 0; c < NUM_CH; c++) begin
			thr[c] = 16'd1;
			lvl_now[c] = '0;
			lvl_sent[c] = '0;
			walk[c] = 0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_item(mk(0, 1, 1, LEVEL_TOP, LEVEL_TOP, LEVEL_TOP), 1, rpt(0, 0, 0, 0));
		add_item(mk(1, 1, 0, 0, 0, 0), 1, rpt(0, 0, 0, 0));
		add_write(REG_MIN_SECONDS, 16'd0);
		add_item(mk(0, 1, 0, 0, 0, 0), 1, rpt(1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		add_item(mk(1, 0, 1, LEVEL_BOTTOM, LEVEL_BOTTOM, LEVEL_BOTTOM), 1, rpt(0, 0, 0, 0));
		add_item(mk(0, 1, 0, 0, 0, 0), 1, rpt(1, 0, 0, 0));
		add_item(mk(0, 1, 1, 0, 0, 0), 1, rpt(1, 0, 0, 0));
		add_item(mk(0, 1, 1, 25600, 25600, 128));
		add_item(mk(0, 1, 1, 25856, 25600, 128));
		add_item(mk(0, 1, 1, 25857, 25600, 128));
		add_write(REG_HELIUM_THR, 16'd0);
		add_write(REG_N2A_THR, 16'hFFFF);
		add_write(REG_N2B_THR, 16'hFFFF);
		add_item(mk(0, 1, 1, 25858, 25600, 128));
		add_item(mk(0, 1, 1, 25858, 25600, 128));
		add_item(mk(0, 1, 1, 1, LEVEL_BOTTOM, LEVEL_TOP));
		add_item(mk(0, 1, 1, 1, LEVEL_TOP, LEVEL_BOTTOM));
		add_item(mk(1, 1, 1, 1, LEVEL_BOTTOM, LEVEL_TOP));
		add_write(REG_MAX_MINUTES, 16'd0);
		add_write(REG_MIN_SECONDS, 16'hFFFF);
		add_item(mk(0, 1, 0, 0, 0, 0));
		add_item(mk(1, 0, 0, 0, 0, 0), 1, rpt(0, 0, 0, 0));
		add_item(mk(1, 1, 1, LEVEL_TOP, 0, 25600));
		add_write(REG_SPARE_LO, 16'd0);
		add_write(REG_SPARE_HI, 16'hFFFF);
		add_item(mk(0, 1, 0, 0, 0, 0));
		add_item(mk(1, 0, 1, -24'sd256, 24'sd256, 24'sd6553));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				settle();
				write_reg(plan[i].idx, plan[i].val);
			end else begin
				send_item(plan[i].item, plan[i].typed, plan[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			write_reg(REG_MIN_SECONDS, pick_reg(2, 0, 30));
			write_reg(REG_MAX_MINUTES, (ph == PHASES - 1) ? 16'd1 : pick_reg(1, 1, 2));
			write_reg(REG_HELIUM_THR, pick_reg(2, 0, 4));
			write_reg(REG_N2A_THR, pick_reg(2, 0, 4));
			write_reg(REG_N2B_THR, pick_reg(2, 0, 4));
			if (ph % 3 == 1)
				write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
					CFG_W'($urandom));
			if (ph == 2)
				squeeze = 1;
			repeat (PHASE_ITEMS)
				send_item(random_item(), 0, '0);
		end

		settle();
		repeat (10) @(posedge clk);
		mismatches += pending_reports.size();
		$display("Run covered %0d items, %0d of them reported, over %0d register writes.",
			items_in, reports_seen, reg_writes);
		$display("Input held off for %0d cycles; %0d mismatches seen.",
			held_cycles, mismatches);
		if (mismatches == 0)
			$display("PASS deadband_report_trigger_unit");
		else
			$display("FAIL deadband_report_trigger_unit");
		$finish;
	end

endmodule
